// ----- hw/rtl/nearest_palette_color_search_defines.svh -----
// Assertion macros shared by the nearest palette color search block.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/npcs_pkg.sv -----
`timescale 1ns / 1ps
package npcs_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int COLOR_W             = 8;
    localparam int INDEX_W             = 8;
    localparam int SQ_W                = 2 * COLOR_W;
    localparam int DIST_W              = 18;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic write;
        logic issue;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last_addr;
        logic pipe_busy;
        logic out_full;
    } t_status;

endpackage

// ----- hw/rtl/npcs_ctrl.sv -----
`timescale 1ns / 1ps
module npcs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_action,
    input  npcs_pkg::t_status i_status,
    output npcs_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);

    npcs_pkg::t_state r_state;
    npcs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            npcs_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_action == npcs_pkg::ACT_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = npcs_pkg::ST_SCAN;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            npcs_pkg::ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_addr) begin
                    n_state = npcs_pkg::ST_DRAIN;
                end
            end
            npcs_pkg::ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = npcs_pkg::ST_FINISH;
                end
            end
            npcs_pkg::ST_FINISH: begin
                if (!i_status.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = npcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = npcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/npcs_dp.sv -----
`timescale 1ns / 1ps
module npcs_dp #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  npcs_pkg::t_cmd                i_cmd,
    output npcs_pkg::t_status             o_status,
    input  logic [npcs_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_red,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_green,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_blue,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [npcs_pkg::INDEX_W-1:0]  o_best_index,
    output logic [npcs_pkg::DIST_W-1:0]   o_best_distance
);

    localparam int AW    = $clog2(PALETTE_ENTRIES);
    localparam int CW    = npcs_pkg::COLOR_W;
    localparam int SQW   = npcs_pkg::SQ_W;
    localparam int DW    = npcs_pkg::DIST_W;
    localparam int ENT_W = 3 * CW;

    logic [ENT_W-1:0]           r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_vld;

    logic                 s_wr_en;
    logic [AW-1:0]        s_wr_addr;

    logic [AW-1:0]        r_addr;
    logic [CW-1:0]        r_q_red;
    logic [CW-1:0]        r_q_green;
    logic [CW-1:0]        r_q_blue;

    logic                 r_s1_v;
    logic [AW-1:0]        r_s1_idx;
    logic [ENT_W-1:0]     r_rd_data;
    logic                 r_rd_ent_v;

    logic                 r_s2_v;
    logic [AW-1:0]        r_s2_idx;
    logic [SQW-1:0]       r_sq_red;
    logic [SQW-1:0]       r_sq_green;
    logic [SQW-1:0]       r_sq_blue;

    logic                 r_have;
    logic [AW-1:0]        r_best_idx;
    logic [DW-1:0]        r_best_dist;

    logic                 r_out_valid;
    logic [AW-1:0]        r_out_idx;
    logic [DW-1:0]        r_out_dist;

    logic [ENT_W-1:0]     s_ent;
    logic [CW-1:0]        s_d_red;
    logic [CW-1:0]        s_d_green;
    logic [CW-1:0]        s_d_blue;
    logic [DW-1:0]        s_sum;
    logic                 s_better;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    assign s_wr_en   = i_cmd.write
                       && ({1'b0, i_entry_index} < (npcs_pkg::INDEX_W + 1)'(PALETTE_ENTRIES));
    assign s_wr_addr = i_entry_index[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_mem[s_wr_addr] <= {i_red, i_green, i_blue};
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_wr_en) begin
            r_vld[s_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ent_v <= r_vld[r_addr];
        r_s1_idx   <= r_addr;
        r_s2_idx   <= r_s1_idx;
        r_sq_red   <= s_d_red * s_d_red;
        r_sq_green <= s_d_green * s_d_green;
        r_sq_blue  <= s_d_blue * s_d_blue;
        if (i_cmd.start) begin
            r_q_red   <= i_red;
            r_q_green <= i_green;
            r_q_blue  <= i_blue;
        end
        if (r_s2_v && s_better) begin
            r_best_idx  <= r_s2_idx;
            r_best_dist <= s_sum;
        end
        if (i_cmd.load_out) begin
            r_out_idx  <= r_best_idx;
            r_out_dist <= r_best_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.issue;
            r_s2_v <= r_s1_v;
            if (i_cmd.start) begin
                r_addr <= '0;
            end else if (i_cmd.issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_cmd.start) begin
                r_have <= 1'b0;
            end else if (r_s2_v) begin
                r_have <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        s_ent     = r_rd_ent_v ? r_rd_data : '0;
        s_d_red   = abs_diff(r_q_red, s_ent[3*CW-1:2*CW]);
        s_d_green = abs_diff(r_q_green, s_ent[2*CW-1:CW]);
        s_d_blue  = abs_diff(r_q_blue, s_ent[CW-1:0]);
        s_sum     = DW'(r_sq_red) + DW'(r_sq_green) + DW'(r_sq_blue);
        s_better  = !r_have || (s_sum < r_best_dist);
    end

    assign o_status.last_addr = (r_addr == AW'(PALETTE_ENTRIES - 1));
    assign o_status.pipe_busy = r_s1_v || r_s2_v;
    assign o_status.out_full  = r_out_valid;

    assign o_out_valid     = r_out_valid;
    assign o_best_index    = npcs_pkg::INDEX_W'(r_out_idx);
    assign o_best_distance = r_out_dist;

endmodule

// ----- hw/rtl/nearest_palette_color_search.sv -----
// A query occupies the block while it scans the palette, one palette entry read per
// cycle from the single read port of the palette memory.
// Reset is synchronous and active low: it clears the control state and the per-entry
// valid bits, so every palette entry reads as zero until it is written.
`timescale 1ns / 1ps
`include "nearest_palette_color_search_defines.svh"
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [npcs_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_red,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_green,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_blue,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [npcs_pkg::INDEX_W-1:0]  o_best_index,
    output logic [npcs_pkg::DIST_W-1:0]   o_best_distance
);

    npcs_pkg::t_cmd    s_cmd;
    npcs_pkg::t_status s_status;

    npcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_status   (s_status),
        .o_cmd      (s_cmd),
        .o_in_stall (o_in_stall)
    );

    npcs_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .o_status        (s_status),
        .i_entry_index   (i_entry_index),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_best_index    (o_best_index),
        .o_best_distance (o_best_distance)
    );

    // A query transaction starts the scan in the next cycle.
    `NPCS_ASSERT_NEXT(a_query_starts_scan, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_action == npcs_pkg::ACT_QUERY, s_cmd.issue, "query did not start the scan")
    // No new transaction is taken while the scan reads the palette.
    `NPCS_ASSERT_SAME(a_no_accept_in_scan, i_clk, i_rst_n, s_cmd.issue, o_in_stall, "input accepted during scan")
    // A result is never loaded over one still waiting to be taken.
    `NPCS_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, s_cmd.load_out, !s_status.out_full, "pending result overwritten")
    // The scan pipeline has drained before its result is loaded.
    `NPCS_ASSERT_SAME(a_drained_on_load, i_clk, i_rst_n, s_cmd.load_out, !s_status.pipe_busy, "result loaded before pipeline drained")

endmodule

// ----- dv/nearest_palette_color_search_tb.sv -----
`timescale 1ns / 1ps
module nearest_palette_color_search_tb;

    localparam int NUM_ENTRIES  = npcs_pkg::PALETTE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1130;
    localparam int IDLE_LIMIT   = 4 * (NUM_ENTRIES + 40);
    localparam int DIST_START   = 32'h7fff_ffff;

    typedef struct packed {
        logic [npcs_pkg::INDEX_W-1:0] index;
        logic [npcs_pkg::DIST_W-1:0]  distance;
    } t_answer;

    class palette_tracker;
        logic [npcs_pkg::COLOR_W-1:0] pal_red   [NUM_ENTRIES];
        logic [npcs_pkg::COLOR_W-1:0] pal_green [NUM_ENTRIES];
        logic [npcs_pkg::COLOR_W-1:0] pal_blue  [NUM_ENTRIES];
        t_answer pending_answers[$];
        int error_count;
        int write_count;
        int query_count;
        int checked_count;
        int exact_count;

        function new();
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                pal_red[i]   = '0;
                pal_green[i] = '0;
                pal_blue[i]  = '0;
            end
            error_count   = 0;
            write_count   = 0;
            query_count   = 0;
            checked_count = 0;
            exact_count   = 0;
        endfunction

        function t_answer find_nearest(logic [npcs_pkg::COLOR_W-1:0] r,
                                       logic [npcs_pkg::COLOR_W-1:0] g,
                                       logic [npcs_pkg::COLOR_W-1:0] b);
            t_answer ans;
            int best_dist;
            int cand_dist;
            int dr;
            int dg;
            int db;
            ans.index = '0;
            best_dist = DIST_START;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                dr = int'(r) - int'(pal_red[i]);
                dg = int'(g) - int'(pal_green[i]);
                db = int'(b) - int'(pal_blue[i]);
                cand_dist = dr * dr + dg * dg + db * db;
                if (cand_dist < best_dist) begin
                    best_dist = cand_dist;
                    ans.index = i[npcs_pkg::INDEX_W-1:0];
                    if (cand_dist == 0) break;
                end
            end
            ans.distance = best_dist[npcs_pkg::DIST_W-1:0];
            return ans;
        endfunction

        function void record_transaction(logic act, logic [npcs_pkg::INDEX_W-1:0] idx,
                                         logic [npcs_pkg::COLOR_W-1:0] r,
                                         logic [npcs_pkg::COLOR_W-1:0] g,
                                         logic [npcs_pkg::COLOR_W-1:0] b);
            t_answer ans;
            if (act == npcs_pkg::ACT_WRITE) begin
                write_count++;
                if (int'(idx) < NUM_ENTRIES) begin
                    pal_red[idx]   = r;
                    pal_green[idx] = g;
                    pal_blue[idx]  = b;
                end
            end else begin
                query_count++;
                ans = find_nearest(r, g, b);
                if (ans.distance == 0) exact_count++;
                pending_answers.push_back(ans);
            end
        endfunction

        function void check_answer(logic [npcs_pkg::INDEX_W-1:0] idx,
                                   logic [npcs_pkg::DIST_W-1:0] got_dist);
            t_answer exp_ans;
            if (pending_answers.size() == 0) begin
                $error("best_index/best_distance: unexpected result, index %0d distance %0d",
                       idx, got_dist);
                error_count++;
            end else begin
                exp_ans = pending_answers.pop_front();
                checked_count++;
                if (idx !== exp_ans.index) begin
                    $error("best_index: expected %0d, actual %0d", exp_ans.index, idx);
                    error_count++;
                end
                if (got_dist !== exp_ans.distance) begin
                    $error("best_distance: expected %0d, actual %0d", exp_ans.distance,
                           got_dist);
                    error_count++;
                end
            end
        endfunction

        function int pending_count();
            return pending_answers.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_action;
    logic [npcs_pkg::INDEX_W-1:0]  i_entry_index;
    logic [npcs_pkg::COLOR_W-1:0]  i_red;
    logic [npcs_pkg::COLOR_W-1:0]  i_green;
    logic [npcs_pkg::COLOR_W-1:0]  i_blue;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [npcs_pkg::INDEX_W-1:0]  o_best_index;
    logic [npcs_pkg::DIST_W-1:0]   o_best_distance;

    palette_tracker sb = new();
    bit quiet_tail = 1'b0;

    nearest_palette_color_search #(
        .PALETTE_ENTRIES(NUM_ENTRIES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_entry_index  (i_entry_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_best_index   (o_best_index),
        .o_best_distance(o_best_distance)
    );

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = npcs_pkg::ACT_WRITE;
        i_entry_index = '0;
        i_red         = '0;
        i_green       = '0;
        i_blue        = '0;
        i_out_stall   = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic logic [npcs_pkg::COLOR_W-1:0] nudge(logic [npcs_pkg::COLOR_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[npcs_pkg::COLOR_W-1:0];
    endfunction

    function automatic logic [npcs_pkg::COLOR_W-1:0] rand_color();
        return npcs_pkg::COLOR_W'($urandom);
    endfunction

    function automatic logic [npcs_pkg::INDEX_W-1:0] rand_index();
        return npcs_pkg::INDEX_W'($urandom);
    endfunction

    task automatic send_transaction(input logic act,
                                    input logic [npcs_pkg::INDEX_W-1:0] idx,
                                    input logic [npcs_pkg::COLOR_W-1:0] r,
                                    input logic [npcs_pkg::COLOR_W-1:0] g,
                                    input logic [npcs_pkg::COLOR_W-1:0] b);
        int gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_entry_index <= idx;
        i_red         <= r;
        i_green       <= g;
        i_blue        <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.record_transaction(act, idx, r, g, b);
    endtask

    task automatic send_random_transaction();
        int kind;
        int k;
        kind = $urandom_range(0, 99);
        k = $urandom_range(0, NUM_ENTRIES - 1);
        if (kind < 35) begin
            send_transaction(npcs_pkg::ACT_WRITE, rand_index(), rand_color(), rand_color(),
                             rand_color());
        end else if (kind < 45) begin
            // A copy of an existing color makes ties between entries.
            send_transaction(npcs_pkg::ACT_WRITE, rand_index(), sb.pal_red[k],
                             sb.pal_green[k], sb.pal_blue[k]);
        end else if (kind < 62) begin
            send_transaction(npcs_pkg::ACT_QUERY, rand_index(), sb.pal_red[k],
                             sb.pal_green[k], sb.pal_blue[k]);
        end else if (kind < 85) begin
            send_transaction(npcs_pkg::ACT_QUERY, rand_index(), nudge(sb.pal_red[k]),
                             nudge(sb.pal_green[k]), nudge(sb.pal_blue[k]));
        end else begin
            send_transaction(npcs_pkg::ACT_QUERY, rand_index(), rand_color(), rand_color(),
                             rand_color());
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_answer(o_best_index, o_best_distance);
        end
    end

    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet_tail && $urandom_range(0, 19) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The untouched palette reads as zero everywhere.
        send_transaction(npcs_pkg::ACT_QUERY, 8'd0,   8'd0,   8'd0,   8'd0);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd255, 8'd255, 8'd255, 8'd255);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd170, 8'd128, 8'd1,   8'd254);
        // An exact match at entry 5 of the palette; the scan still reads every entry.
        send_transaction(npcs_pkg::ACT_WRITE, 8'd5,   8'd10,  8'd20,  8'd30);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd85,  8'd10,  8'd20,  8'd30);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd0,   8'd11,  8'd20,  8'd30);
        send_transaction(npcs_pkg::ACT_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd0,   8'd255, 8'd255, 8'd255);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd0,   8'd250, 8'd255, 8'd255);
        // Equal entries at both ends of the palette: the lower index wins.
        send_transaction(npcs_pkg::ACT_WRITE, 8'd0,   8'd255, 8'd255, 8'd255);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd255, 8'd255, 8'd255, 8'd255);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd0,   8'd0,   8'd0,   8'd0);
        send_transaction(npcs_pkg::ACT_WRITE, 8'd0,   8'd0,   8'd0,   8'd0);
        send_transaction(npcs_pkg::ACT_WRITE, 8'd200, 8'd100, 8'd100, 8'd100);
        send_transaction(npcs_pkg::ACT_WRITE, 8'd100, 8'd100, 8'd100, 8'd100);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd0,   8'd100, 8'd100, 8'd101);
        send_transaction(npcs_pkg::ACT_WRITE, 8'd7,   8'd0,   8'd255, 8'd0);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd7,   8'd0,   8'd255, 8'd0);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd170, 8'd170, 8'd85,  8'd170);
        send_transaction(npcs_pkg::ACT_QUERY, 8'd85,  8'd85,  8'd170, 8'd85);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet_tail = (n >= RANDOM_ITEMS * 85 / 100);
            send_random_transaction();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (NUM_ENTRIES + 10) @(posedge i_clk);

        $display("Run covered %0d palette writes and %0d color queries.",
                 sb.write_count, sb.query_count);
        $display("%0d answers were checked, %0d of them exact matches.",
                 sb.checked_count, sb.exact_count);
        if (sb.error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
